>>> sv/mrtu_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the RTU request framer.
// No dependencies; every other file of the framer but mrtu_checker imports this package.
package mrtu_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WORDS = 2'd1;
  localparam logic [1:0] PH_COILS = 2'd2;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_SLAVE = 3'd1;
  localparam logic [2:0] ERR_FUNC  = 3'd2;
  localparam logic [2:0] ERR_QUANT = 3'd3;
  localparam logic [2:0] ERR_ADDR  = 3'd4;
  localparam logic [2:0] ERR_COIL  = 3'd5;
  localparam logic [2:0] ERR_COUNT = 3'd6;
  localparam logic [2:0] ERR_NOREQ = 3'd7;

  localparam logic [7:0] FC_RD_COILS     = 8'd1;
  localparam logic [7:0] FC_RD_INPUTS    = 8'd2;
  localparam logic [7:0] FC_RD_HOLDING   = 8'd3;
  localparam logic [7:0] FC_RD_INPUT_REG = 8'd4;
  localparam logic [7:0] FC_WR_COIL      = 8'd5;
  localparam logic [7:0] FC_WR_REG       = 8'd6;
  localparam logic [7:0] FC_WR_COILS     = 8'd15;
  localparam logic [7:0] FC_WR_REGS      = 8'd16;

  localparam logic [7:0]  SLAVE_MAX      = 8'd247;
  localparam logic [15:0] QMAX_BITS      = 16'd2000;
  localparam logic [15:0] QMAX_REGS      = 16'd125;
  localparam logic [15:0] QMAX_WR_COILS  = 16'd1968;
  localparam logic [15:0] QMAX_WR_REGS   = 16'd123;
  localparam logic [15:0] COIL_ON        = 16'hFF00;
  localparam logic [15:0] COIL_OFF       = 16'h0000;
  localparam logic [4:0]  COIL_CNT_MAX   = 5'd16;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef struct packed {
    logic        operation;
    logic [7:0]  slave;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic [15:0] data_value;
    logic [4:0]  coil_count;
    logic        last_data;
  } in_item_t;

  // One command for the byte sequencer: up to seven frame bytes, optional
  // CRC trailer, or a single error result when err is nonzero.
  typedef struct packed {
    logic [2:0]      err;
    logic            reset_crc;
    logic            append_crc;
    logic [2:0]      nbytes;
    logic [6:0][7:0] bytes;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> sv/mrtu_front.sv
// Front end of the RTU request framer: accepts requests, runs the header checks,
// tracks the open request and packs coils, then pushes byte commands. Uses mrtu_pkg.
module mrtu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrtu_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              push,
  output mrtu_pkg::cmd_t    cmd
);
  import mrtu_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [10:0] items_left, items_left_next;
  logic [7:0]  coil_acc, coil_acc_next;
  logic [2:0]  coil_fill, coil_fill_next;
  logic        accept;
  logic        emit;

  logic [15:0] qmax;
  logic        fc_ok;
  logic [16:0] addr_sum;
  logic [16:0] q_plus7;
  logic [4:0]  cnt_sat;
  logic [16:0] mask;
  logic [15:0] data_m;
  logic [23:0] packed_bits;
  logic [4:0]  total_bits;
  logic [1:0]  full_bytes;
  logic [2:0]  fill_new;
  logic        extra_byte;
  logic [10:0] cnt_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && emit;

  always_comb begin
    qmax  = '0;
    fc_ok = 1'b1;
    unique case (in_item.function_code)
      FC_RD_COILS, FC_RD_INPUTS:     qmax = QMAX_BITS;
      FC_RD_HOLDING, FC_RD_INPUT_REG: qmax = QMAX_REGS;
      FC_WR_COILS:                   qmax = QMAX_WR_COILS;
      FC_WR_REGS:                    qmax = QMAX_WR_REGS;
      FC_WR_COIL, FC_WR_REG:         qmax = '0;
      default:                       fc_ok = 1'b0;
    endcase
  end

  assign addr_sum = {1'b0, in_item.start_address} + {1'b0, in_item.quantity_or_value};
  assign q_plus7  = {1'b0, in_item.quantity_or_value} + 17'd7;

  // Coil packing: new bits land above the fill already held in the accumulator.
  assign cnt_sat     = (in_item.coil_count > COIL_CNT_MAX) ? COIL_CNT_MAX : in_item.coil_count;
  assign mask        = (17'd1 << cnt_sat) - 17'd1;
  assign data_m      = in_item.data_value & mask[15:0];
  assign packed_bits = {16'h0000, coil_acc} | ({8'h00, data_m} << coil_fill);
  assign total_bits  = {2'b00, coil_fill} + cnt_sat;
  assign full_bytes  = total_bits[4:3];
  assign fill_new    = total_bits[2:0];
  assign extra_byte  = in_item.last_data && (fill_new != 3'd0);
  assign cnt_ext     = {6'b0, cnt_sat};

  always_comb begin
    phase_next      = phase;
    items_left_next = items_left;
    coil_acc_next   = coil_acc;
    coil_fill_next  = coil_fill;
    emit            = 1'b0;
    cmd             = '0;
    if (!in_item.operation) begin
      phase_next      = PH_IDLE;
      items_left_next = '0;
      coil_acc_next   = '0;
      coil_fill_next  = '0;
      emit            = 1'b1;
      priority if (in_item.slave == 8'd0 || in_item.slave > SLAVE_MAX) begin
        cmd.err = ERR_SLAVE;
      end else if (!fc_ok) begin
        cmd.err = ERR_FUNC;
      end else if (qmax != 16'd0 &&
                   (in_item.quantity_or_value == 16'd0 || in_item.quantity_or_value > qmax)) begin
        cmd.err = ERR_QUANT;
      end else if (qmax != 16'd0 && addr_sum > 17'h10000) begin
        cmd.err = ERR_ADDR;
      end else if (in_item.function_code == FC_WR_COIL &&
                   in_item.quantity_or_value != COIL_ON &&
                   in_item.quantity_or_value != COIL_OFF) begin
        cmd.err = ERR_COIL;
      end else begin
        cmd.reset_crc = 1'b1;
        cmd.bytes[0]  = in_item.slave;
        cmd.bytes[1]  = in_item.function_code;
        cmd.bytes[2]  = in_item.start_address[15:8];
        cmd.bytes[3]  = in_item.start_address[7:0];
        cmd.bytes[4]  = in_item.quantity_or_value[15:8];
        cmd.bytes[5]  = in_item.quantity_or_value[7:0];
        if (in_item.function_code == FC_WR_COILS) begin
          cmd.bytes[6]    = q_plus7[10:3];
          cmd.nbytes      = 3'd7;
          phase_next      = PH_COILS;
          items_left_next = in_item.quantity_or_value[10:0];
        end else if (in_item.function_code == FC_WR_REGS) begin
          cmd.bytes[6]    = {in_item.quantity_or_value[6:0], 1'b0};
          cmd.nbytes      = 3'd7;
          phase_next      = PH_WORDS;
          items_left_next = in_item.quantity_or_value[10:0];
        end else begin
          cmd.nbytes     = 3'd6;
          cmd.append_crc = 1'b1;
        end
      end
    end else begin
      unique case (phase)
        PH_WORDS: begin
          emit = 1'b1;
          if (items_left == 11'd0 || (in_item.last_data && items_left != 11'd1)) begin
            cmd.err         = ERR_COUNT;
            phase_next      = PH_IDLE;
            items_left_next = '0;
          end else begin
            cmd.bytes[0]    = in_item.data_value[15:8];
            cmd.bytes[1]    = in_item.data_value[7:0];
            cmd.nbytes      = 3'd2;
            cmd.append_crc  = in_item.last_data;
            items_left_next = items_left - 11'd1;
            if (in_item.last_data) begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_COILS: begin
          if (cnt_ext > items_left || (in_item.last_data && cnt_ext != items_left)) begin
            emit            = 1'b1;
            cmd.err         = ERR_COUNT;
            phase_next      = PH_IDLE;
            items_left_next = '0;
            coil_acc_next   = '0;
            coil_fill_next  = '0;
          end else begin
            cmd.bytes[0]   = packed_bits[7:0];
            cmd.bytes[1]   = packed_bits[15:8];
            cmd.bytes[2]   = packed_bits[23:16];
            cmd.nbytes     = {1'b0, full_bytes} + {2'b00, extra_byte};
            cmd.append_crc = in_item.last_data;
            emit           = (full_bytes != 2'd0) || in_item.last_data;
            if (in_item.last_data) begin
              phase_next      = PH_IDLE;
              items_left_next = '0;
              coil_acc_next   = '0;
              coil_fill_next  = '0;
            end else begin
              items_left_next = items_left - cnt_ext;
              coil_acc_next   = 8'(packed_bits >> {full_bytes, 3'b000});
              coil_fill_next  = fill_new;
            end
          end
        end
        default: begin
          emit    = 1'b1;
          cmd.err = ERR_NOREQ;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      items_left <= '0;
      coil_acc   <= '0;
      coil_fill  <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      items_left <= items_left_next;
      coil_acc   <= coil_acc_next;
      coil_fill  <= coil_fill_next;
    end
  end

endmodule

>>> sv/mrtu_queue.sv
// Short command queue between the framer's front end and its byte sequencer.
// Circular buffer of mrtu_pkg::cmd_t entries; depth is a parameter.
module mrtu_queue #(
  parameter int DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrtu_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mrtu_pkg::cmd_t head
);
  import mrtu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> sv/mrtu_back.sv
// Byte sequencer of the RTU request framer: walks the head command one byte per cycle
// while out_ready is high, keeps the running CRC-16/MODBUS and appends it. Uses mrtu_pkg.
module mrtu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           not_empty,
  input  mrtu_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     frame_byte,
  output logic [2:0]     error_code,
  output logic           last_of_run,
  output logic           frame_done
);
  import mrtu_pkg::*;

  logic [2:0]  idx;
  logic [15:0] crc;
  logic [15:0] crc_in;
  logic [3:0]  total;
  logic        is_data;
  logic        take;

  assign out_valid = not_empty;
  assign take      = out_valid && out_ready;
  assign total     = (head.err != ERR_NONE) ? 4'd1
                   : ({1'b0, head.nbytes} + (head.append_crc ? 4'd2 : 4'd0));
  assign crc_in    = (head.reset_crc && idx == 3'd0) ? CRC_INIT : crc;
  assign last_of_run = ({1'b0, idx} == total - 4'd1);
  assign pop       = take && last_of_run;

  always_comb begin
    frame_byte = '0;
    error_code = head.err;
    frame_done = 1'b0;
    is_data    = 1'b0;
    if (head.err == ERR_NONE) begin
      if (idx < head.nbytes) begin
        frame_byte = head.bytes[idx];
        is_data    = 1'b1;
      end else if (idx == head.nbytes) begin
        frame_byte = crc_in[7:0];
      end else begin
        frame_byte = crc_in[15:8];
        frame_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      crc <= CRC_INIT;
    end else if (take) begin
      idx <= last_of_run ? 3'd0 : idx + 3'd1;
      if (is_data) begin
        crc <= crc_byte(crc_in, frame_byte);
      end
    end
  end

endmodule

>>> sv/modbus_rtu_request_framer.sv
// Modbus RTU request framer: one request item per cycle in while the command queue has
// room, one frame byte per cycle out while m_tready is high, CRC-16/MODBUS appended low
// byte first. Uses mrtu_pkg and its submodules.
// A user sees this: an input request is taken in the cycle it is offered as long
// as the command queue (QUEUE_DEPTH entries, two by default) has room, so requests
// may follow each other back to back. Each request produces zero to eight results,
// and the output byte sequencer delivers exactly one of them per cycle while
// m_tready is high. A request gives one result for an error, two for a register word
// (four when it closes the frame), up to eight for a complete read request. A header
// item with a bad slave, function, quantity, address range or single-coil value yields
// one error result and leaves no request open. No clearing pass follows reset; the
// queue is empty and s_tready is high once reset is released.
module modbus_rtu_request_framer #(
  parameter int QUEUE_DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slave[7:0], function_code[15:8], start_address[31:16],
  // quantity_or_value[47:32], data_value[63:48], coil_count[68:64], zero [71:69]
  input  logic [71:0] s_tdata,
  input  logic        s_tuser,  // operation
  input  logic        s_tlast,  // last_data
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_byte[7:0], error_code[10:8], zero [15:11]
  output logic [15:0] m_tdata,
  output logic        m_tuser,  // last_of_run
  output logic        m_tlast   // frame_done
);
  import mrtu_pkg::*;

  in_item_t   in_item;
  cmd_t       push_cmd;
  cmd_t       head;
  logic       push;
  logic       q_full;
  logic       pop;
  logic       not_empty;
  logic [7:0] frame_byte;
  logic [2:0] error_code;

  assign in_item.operation         = s_tuser;
  assign in_item.slave             = s_tdata[7:0];
  assign in_item.function_code     = s_tdata[15:8];
  assign in_item.start_address     = s_tdata[31:16];
  assign in_item.quantity_or_value = s_tdata[47:32];
  assign in_item.data_value        = s_tdata[63:48];
  assign in_item.coil_count        = s_tdata[68:64];
  assign in_item.last_data         = s_tlast;

  mrtu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  mrtu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  mrtu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .not_empty   (not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .frame_byte  (frame_byte),
    .error_code  (error_code),
    .last_of_run (m_tuser),
    .frame_done  (m_tlast)
  );

  assign m_tdata = {5'b00000, error_code, frame_byte};

endmodule

>>> sv/mrtu_checker.sv
// Port-level checks for the RTU request framer, attached by the bind at the end.
// Sees only the top-level ports; no package dependency.
module mrtu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [71:0] s_tdata,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // An error result carries no frame byte, closes its run and ends no frame.
  a_error_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10:8] != 3'd0 |-> m_tdata[7:0] == 8'd0 && m_tuser && !m_tlast)
    else $error("error result with frame byte, open run or frame end");

  // The CRC high byte is always the final result of its request.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser && m_tdata[10:8] == 3'd0)
    else $error("frame end not marked as last of run");

  // A stalled result holds its value, including the CRC bytes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output result changed while stalled");

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("result pending or input stalled after reset");

endmodule

bind modbus_rtu_request_framer mrtu_checker u_mrtu_checker (.*);

>>> tb/mrtu_frame_checker.sv
// Frame checker for the RTU request framer: predicts the frame bytes of every request.
// Watches both stream channels and compares each result in order. Depends on mrtu_pkg.
`timescale 1ns / 1ps

module mrtu_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          mismatch_count,
  output int          results_due
);
  import mrtu_pkg::*;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [2:0] error_code;
    logic       run_last;
    logic       frame_done;
  } frame_result_t;

  frame_result_t frame_bytes_due[$];

  logic [1:0]  req_phase;
  logic [7:0]  open_fc;
  logic [10:0] units_left;
  logic [15:0] frame_crc;
  logic [7:0]  coil_acc;
  logic [2:0]  coil_fill;

  // Reflected CRC-16/MODBUS, one data bit at a time.
  function automatic logic [15:0] crc16_modbus_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r = r >> 1;
      if (fb) r = r ^ 16'hA001;
    end
    return r;
  endfunction

  function automatic void drop_request();
    req_phase  = PH_IDLE;
    open_fc    = 8'd0;
    units_left = 11'd0;
    coil_acc   = 8'd0;
    coil_fill  = 3'd0;
  endfunction

  function automatic void push_result(logic [7:0] b, logic [2:0] e, logic done);
    frame_result_t r;
    r.frame_byte = b;
    r.error_code = e;
    r.run_last   = 1'b0;
    r.frame_done = done;
    frame_bytes_due = {frame_bytes_due, r};
  endfunction

  function automatic void send_byte(logic [7:0] b);
    frame_crc = crc16_modbus_step(frame_crc, b);
    push_result(b, ERR_NONE, 1'b0);
  endfunction

  function automatic void close_frame();
    logic [15:0] c;
    c = frame_crc;
    push_result(c[7:0], ERR_NONE, 1'b0);
    push_result(c[15:8], ERR_NONE, 1'b1);
    drop_request();
  endfunction

  function automatic void reject(logic [2:0] e);
    drop_request();
    push_result(8'h00, e, 1'b0);
  endfunction

  function automatic void take_header(in_item_t it);
    logic [15:0] qmax;
    logic [2:0]  err;
    logic [15:0] q;
    q    = it.quantity_or_value;
    qmax = 16'd0;
    err  = ERR_NONE;
    drop_request();
    case (it.function_code)
      FC_RD_COILS, FC_RD_INPUTS:       qmax = QMAX_BITS;
      FC_RD_HOLDING, FC_RD_INPUT_REG:  qmax = QMAX_REGS;
      FC_WR_COILS:                     qmax = QMAX_WR_COILS;
      FC_WR_REGS:                      qmax = QMAX_WR_REGS;
      FC_WR_COIL, FC_WR_REG:           qmax = 16'd0;
      default:                         err = ERR_FUNC;
    endcase
    // The slave check wins over every other header check.
    if (it.slave == 8'd0 || it.slave > SLAVE_MAX) begin
      err = ERR_SLAVE;
    end else if (err == ERR_NONE && qmax != 16'd0) begin
      if (q == 16'd0 || q > qmax) err = ERR_QUANT;
      else if ({1'b0, it.start_address} + {1'b0, q} - 17'd1 > 17'h0FFFF) err = ERR_ADDR;
    end
    if (err == ERR_NONE && it.function_code == FC_WR_COIL && q != COIL_ON && q != COIL_OFF)
      err = ERR_COIL;
    if (err != ERR_NONE) begin
      reject(err);
      return;
    end
    frame_crc = CRC_INIT;
    send_byte(it.slave);
    send_byte(it.function_code);
    send_byte(it.start_address[15:8]);
    send_byte(it.start_address[7:0]);
    send_byte(q[15:8]);
    send_byte(q[7:0]);
    if (it.function_code == FC_WR_COILS) begin
      send_byte(8'((q + 16'd7) >> 3));
      req_phase  = PH_COILS;
      open_fc    = it.function_code;
      units_left = q[10:0];
    end else if (it.function_code == FC_WR_REGS) begin
      send_byte(8'(q << 1));
      req_phase  = PH_WORDS;
      open_fc    = it.function_code;
      units_left = q[10:0];
    end else begin
      close_frame();
    end
  endfunction

  function automatic void take_payload(in_item_t it);
    logic [4:0] cnt;
    if (req_phase == PH_WORDS) begin
      if (units_left == 11'd0 || (it.last_data && units_left != 11'd1)) begin
        reject(ERR_COUNT);
        return;
      end
      send_byte(it.data_value[15:8]);
      send_byte(it.data_value[7:0]);
      units_left = units_left - 11'd1;
      if (it.last_data) close_frame();
    end else if (req_phase == PH_COILS) begin
      cnt = (it.coil_count > COIL_CNT_MAX) ? COIL_CNT_MAX : it.coil_count;
      if ({6'd0, cnt} > units_left || (it.last_data && {6'd0, cnt} != units_left)) begin
        reject(ERR_COUNT);
        return;
      end
      for (int i = 0; i < 16; i++) begin
        if (i < int'(cnt)) begin
          coil_acc[coil_fill] = it.data_value[i];
          if (coil_fill == 3'd7) begin
            send_byte(coil_acc);
            coil_acc  = 8'd0;
            coil_fill = 3'd0;
          end else begin
            coil_fill = coil_fill + 3'd1;
          end
        end
      end
      units_left = units_left - {6'd0, cnt};
      if (it.last_data) begin
        if (coil_fill != 3'd0) send_byte(coil_acc);
        close_frame();
      end
    end else begin
      reject(ERR_NOREQ);
    end
  endfunction

  function automatic void note_mismatch(string what, frame_result_t want, frame_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %02h err %0d run %b done %b, actual %02h err %0d run %b done %b",
               $time, what, want.frame_byte, want.error_code, want.run_last, want.frame_done,
               got.frame_byte, got.error_code, got.run_last, got.frame_done);
  endfunction

  always @(posedge clk) begin : watch
    in_item_t      req;
    frame_result_t got;
    frame_result_t want;
    int            size_before;
    if (rst) begin
      frame_bytes_due.delete();
      drop_request();
      frame_crc      = CRC_INIT;
      mismatch_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        req.operation         = s_tuser;
        req.slave             = s_tdata[7:0];
        req.function_code     = s_tdata[15:8];
        req.start_address     = s_tdata[31:16];
        req.quantity_or_value = s_tdata[47:32];
        req.data_value        = s_tdata[63:48];
        req.coil_count        = s_tdata[68:64];
        req.last_data         = s_tlast;
        size_before = frame_bytes_due.size();
        if (req.operation) take_payload(req);
        else take_header(req);
        // The newest result of this request carries the end-of-run mark.
        if (frame_bytes_due.size() > size_before) begin
          frame_bytes_due[frame_bytes_due.size() - 1].run_last = 1'b1;
        end
      end
      if (m_tvalid && m_tready) begin
        got.frame_byte = m_tdata[7:0];
        got.error_code = m_tdata[10:8];
        got.run_last   = m_tuser;
        got.frame_done = m_tlast;
        if (frame_bytes_due.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = frame_bytes_due.pop_front();
          if (want != got) note_mismatch("frame result differs", want, got);
        end
      end
    end
    results_due = frame_bytes_due.size();
  end

endmodule

>>> tb/tb_modbus_rtu_request_framer.sv
// Top of the RTU request framer test: clock, reset, request stimulus and the verdict.
// Instantiates modbus_rtu_request_framer and mrtu_frame_checker; uses mrtu_pkg.
`timescale 1ns / 1ps

module tb_modbus_rtu_request_framer;
  import mrtu_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int mismatch_count;
  int results_due;
  int send_idle;
  int rx_stall;
  int requests_sent;
  int phase_end;
  bit hold_off;

  modbus_rtu_request_framer u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  mrtu_frame_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output side: random stalls, or one long hold-off when asked for.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck = 0;
      else stuck++;
    end
    $display("modbus_rtu_request_framer: mismatch");
    $finish;
  end

  // Fields a header does not use are filled at random.
  function automatic in_item_t head(logic [7:0] sl, logic [7:0] fc, logic [15:0] addr,
                                    logic [15:0] q);
    in_item_t it;
    it.operation         = 1'b0;
    it.slave             = sl;
    it.function_code     = fc;
    it.start_address     = addr;
    it.quantity_or_value = q;
    it.data_value        = 16'($urandom);
    it.coil_count        = 5'($urandom);
    it.last_data         = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t body(logic [15:0] d, logic [4:0] cnt, logic last);
    in_item_t it;
    it.operation         = 1'b1;
    it.slave             = 8'($urandom);
    it.function_code     = 8'($urandom);
    it.start_address     = 16'($urandom);
    it.quantity_or_value = 16'($urandom);
    it.data_value        = d;
    it.coil_count        = cnt;
    it.last_data         = last;
    return it;
  endfunction

  task automatic offer(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.operation;
    s_tlast  <= it.last_data;
    s_tdata  <= {3'b000, it.coil_count, it.data_value, it.quantity_or_value,
                 it.start_address, it.function_code, it.slave};
    requests_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic random_request();
    logic [7:0]  fc;
    logic [15:0] q;
    logic [15:0] addr;
    logic [4:0]  cnt_field;
    int          pick;
    int          brk;
    int          stop;
    int          n;
    int          left;
    int          cnt;
    bit          big;
    pick = $urandom_range(99);
    if (pick < 6) begin
      offer(head(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)));
      return;
    end
    if (pick < 10) begin
      offer(body(16'($urandom), 5'($urandom), 1'($urandom)));
      return;
    end
    case ($urandom_range(7))
      0:       fc = FC_RD_COILS;
      1:       fc = FC_RD_INPUTS;
      2:       fc = FC_RD_HOLDING;
      3:       fc = FC_RD_INPUT_REG;
      4:       fc = FC_WR_COIL;
      5:       fc = FC_WR_REG;
      6:       fc = FC_WR_COILS;
      default: fc = FC_WR_REGS;
    endcase
    // Most requests are small; a few go up to the largest legal quantity.
    big = ($urandom_range(24) == 0);
    case (fc)
      FC_RD_COILS, FC_RD_INPUTS:
        q = big ? 16'($urandom_range(2000, 1)) : 16'($urandom_range(16, 1));
      FC_RD_HOLDING, FC_RD_INPUT_REG:
        q = 16'($urandom_range(125, 1));
      FC_WR_COIL:
        q = ($urandom_range(3) == 0) ? 16'($urandom) :
            (($urandom_range(1) == 0) ? COIL_ON : COIL_OFF);
      FC_WR_REG:
        q = 16'($urandom);
      FC_WR_COILS:
        q = big ? 16'($urandom_range(1968, 1)) : 16'($urandom_range(40, 1));
      default:
        q = big ? 16'($urandom_range(123, 1)) : 16'($urandom_range(6, 1));
    endcase
    if ($urandom_range(19) == 0) q = 16'($urandom);
    addr = ($urandom_range(9) == 0) ? 16'hFFFF - 16'($urandom_range(20)) : 16'($urandom);
    offer(head(8'($urandom_range(247, 1)), fc, addr, q));

    brk = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
    if (fc == FC_WR_REGS) begin
      n = int'(q);
      if (n > 123) n = $urandom_range(4, 1);
      if (n == 0) n = 1;
      stop = $urandom_range(n - 1);
      for (int i = 0; i < n; i++) begin
        if (brk == 2 && i == stop) break;
        offer(body(16'($urandom), 5'($urandom),
                   (brk == 1) ? (i == stop) : (brk != 3 && i == n - 1)));
        if (brk == 1 && i == stop) break;
      end
      if (brk == 3) offer(body(16'($urandom), 5'($urandom), 1'($urandom)));
    end else if (fc == FC_WR_COILS) begin
      left = int'(q);
      if (left > 1968) left = $urandom_range(20, 1);
      while (left > 0) begin
        cnt = $urandom_range(16);
        if (cnt > left) cnt = left;
        if (brk == 2 && ($urandom_range(2) == 0 || cnt == left)) break;
        if (brk == 1 && ($urandom_range(2) == 0 || cnt == left)) begin
          // Either more coils than are left, or an early last item.
          if (left < 16) offer(body(16'($urandom), 5'(left + 1), 1'($urandom)));
          else offer(body(16'($urandom), 5'($urandom_range(15)), 1'b1));
          break;
        end
        cnt_field = 5'(cnt);
        if (cnt == 16 && $urandom_range(1) == 0) cnt_field = 5'($urandom_range(31, 16));
        offer(body(16'($urandom), cnt_field, cnt == left));
        left = left - cnt;
      end
      if (brk == 3) offer(body(16'($urandom), 5'($urandom), 1'($urandom)));
    end
  endtask

  task automatic random_phase(int idle_pct, int stall_pct, int count);
    send_idle = idle_pct;
    rx_stall  = stall_pct;
    phase_end = requests_sent + count;
    while (requests_sent < phase_end) random_request();
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    s_tlast       = 1'b0;
    send_idle     = 0;
    rx_stall      = 0;
    hold_off      = 1'b0;
    requests_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Payload with no request open.
    offer(body(16'hFFFF, 5'd16, 1'b1));
    // Header checks, each in turn, and the slave check taking priority.
    offer(head(8'd0, FC_RD_HOLDING, 16'h0000, 16'd1));
    offer(head(8'd255, 8'd0, 16'h0000, 16'd1));
    offer(head(8'd247, 8'hFF, 16'h0000, 16'd1));
    offer(head(8'd1, FC_RD_HOLDING, 16'h0000, 16'd0));
    offer(head(8'd1, FC_RD_COILS, 16'h0000, 16'd2001));
    offer(head(8'd9, FC_RD_INPUT_REG, 16'hFFFF, 16'd2));
    offer(head(8'd9, FC_WR_COIL, 16'h0010, 16'h1234));
    // Legal extremes; the single writes skip the address range check.
    offer(head(8'd1, FC_WR_COIL, 16'hFFFF, COIL_ON));
    offer(head(8'd247, FC_WR_REG, 16'h0000, 16'hFFFF));
    offer(head(8'd17, FC_RD_INPUTS, 16'h0000, QMAX_BITS));
    offer(head(8'd17, FC_RD_HOLDING, 16'hFF83, QMAX_REGS));
    // Two register words, then a last flag that comes one word too early.
    offer(head(8'd5, FC_WR_REGS, 16'h1234, 16'd2));
    offer(body(16'hFFFF, 5'd0, 1'b0));
    offer(body(16'h0000, 5'd31, 1'b1));
    offer(head(8'd5, FC_WR_REGS, 16'h0001, 16'd2));
    offer(body(16'hA55A, 5'd1, 1'b1));
    // Coils: an empty item, a saturated count, and a short final item.
    offer(head(8'd33, FC_WR_COILS, 16'h0100, 16'd20));
    offer(body(16'hFFFF, 5'd0, 1'b0));
    offer(body(16'hAAAA, 5'd31, 1'b0));
    offer(body(16'h0005, 5'd4, 1'b1));
    // More coils than are left, and an empty item flagged as last.
    offer(head(8'd33, FC_WR_COILS, 16'h0000, 16'd3));
    offer(body(16'h0007, 5'd4, 1'b0));
    offer(head(8'd33, FC_WR_COILS, 16'h0000, 16'd3));
    offer(body(16'h0000, 5'd0, 1'b1));
    // Largest write quantities, each dropped by the header that follows.
    offer(head(8'd200, FC_WR_COILS, 16'h0000, QMAX_WR_COILS));
    offer(head(8'd200, FC_WR_REGS, 16'hFF85, QMAX_WR_REGS));
    offer(head(8'd200, FC_WR_COILS, 16'h0000, 16'd1969));
    offer(head(8'd200, FC_WR_REGS, 16'h0000, 16'd124));
    drain();

    // Long output hold-off while reads keep coming, so the input side backs up.
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++)
      offer(head(8'($urandom_range(247, 1)), FC_RD_HOLDING, 16'($urandom_range(1000)),
                 16'($urandom_range(125, 1))));
    drain();

    random_phase(0, 0, 78);
    random_phase(81, 0, 78);
    random_phase(0, 81, 78);
    random_phase(38, 38, 78);

    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("modbus_rtu_request_framer: match");
    end else begin
      $display("modbus_rtu_request_framer: mismatch");
    end
    $finish;
  end

endmodule
